// File: rtl/tmcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int ADDR_W   = 11;
  localparam int DATA_W   = CHAR_W + ATTR_W;
  localparam int BASE_W   = ROW_W + COL_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUT_CHAR = 3'd0,
    OP_SET_ATTR = 3'd1,
    OP_SET_FG   = 3'd2,
    OP_SET_BG   = 3'd3,
    OP_MOVE     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_NEWLINE,
    KIND_ATTR,
    KIND_MOVE,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr_val;
    logic [ATTR_W-1:0] attr_mask;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BASE_W-1:0] row_base;
  } dcmd_t;

endpackage
`default_nettype wire

// File: rtl/tmcw_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_if
// Command and result channels of the text-mode console writer.
// ----------------------------------------------------------------------------
interface tmcw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tmcw_pkg::OP_W-1:0]    op;
  logic [tmcw_pkg::CHAR_W-1:0]  char_code;
  logic [tmcw_pkg::ATTR_W-1:0]  color_value;
  logic [tmcw_pkg::ROW_W-1:0]   goto_row;
  logic [tmcw_pkg::COL_W-1:0]   goto_col;

  modport source (output valid, op, char_code, color_value, goto_row, goto_col,
                  input ready);
  modport sink (input valid, op, char_code, color_value, goto_row, goto_col,
                output ready);
endinterface

interface tmcw_res_if;
  logic                         valid;
  logic                         ready;
  logic                         write_valid;
  logic [tmcw_pkg::ADDR_W-1:0]  write_addr;
  logic [tmcw_pkg::DATA_W-1:0]  write_data;
  logic [tmcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tmcw_pkg::COL_W-1:0]   cursor_col;
  logic [tmcw_pkg::ATTR_W-1:0]  attribute;

  modport source (output valid, write_valid, write_addr, write_data, cursor_row,
                  cursor_col, attribute, input ready);
  modport sink (input valid, write_valid, write_addr, write_data, cursor_row,
                cursor_col, attribute, output ready);
endinterface
`default_nettype wire

// File: rtl/text_mode_console_writer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Text console cursor engine: turns commands into screen cell writes.
//
// Channels: cmd carries one command per transaction (op, char_code,
// color_value, goto_row, goto_col); res returns exactly one result per
// command, in order: the cell write (write_valid, write_addr, write_data)
// and the cursor position and attribute after that command.
// A command is written into the queue, then into the result register, before
// its result is visible on res.
// Throughput: one command per cycle while res.ready stays high, with the cursor
// update done in the back end (row base plus column add, increment and wrap).
// Reset: cursor goes to row 0, column 0, attribute to 0x07; queue and
// result register are emptied.
// Stall: a result waits in the output register and holds the back end; the
// two-entry queue takes two more commands, then cmd.ready drops.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core (
  input logic        clk,
  input logic        rst,
  tmcw_cmd_if.sink   cmd,
  tmcw_res_if.source res
);
  import tmcw_pkg::*;

  logic  push_valid;
  logic  push_ready;
  dcmd_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  dcmd_t pop_data;

  tmcw_decode u_decode (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tmcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tmcw_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res       (res)
  );

endmodule
`default_nettype wire

// File: rtl/tmcw_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_decode
// Front end: classify commands, saturate moves, build attribute masks.
// ----------------------------------------------------------------------------
module tmcw_decode (
  tmcw_cmd_if.sink          cmd,
  output logic              push_valid,
  input  logic              push_ready,
  output tmcw_pkg::dcmd_t   push_data
);
  import tmcw_pkg::*;

  logic [ROW_W-1:0] sat_row;
  logic [COL_W-1:0] sat_col;

  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid;

  assign sat_row = (cmd.goto_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : cmd.goto_row;
  assign sat_col = (cmd.goto_col > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : cmd.goto_col;

  always_comb begin
    push_data           = '0;
    push_data.kind      = KIND_NOP;
    push_data.char_code = cmd.char_code;
    push_data.row       = sat_row;
    push_data.col       = sat_col;
    push_data.row_base  = BASE_W'(BASE_W'(sat_row) * BASE_W'(COLS));
    unique case (op_t'(cmd.op))
      OP_PUT_CHAR: begin
        push_data.kind = (cmd.char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_WRITE;
      end
      OP_SET_ATTR: begin
        push_data.kind      = KIND_ATTR;
        push_data.attr_val  = cmd.color_value;
        push_data.attr_mask = 8'hFF;
      end
      OP_SET_FG: begin
        push_data.kind      = KIND_ATTR;
        push_data.attr_val  = {4'h0, cmd.color_value[3:0]};
        push_data.attr_mask = 8'h0F;
      end
      OP_SET_BG: begin
        push_data.kind      = KIND_ATTR;
        push_data.attr_val  = {cmd.color_value[3:0], 4'h0};
        push_data.attr_mask = 8'hF0;
      end
      OP_MOVE: begin
        push_data.kind = KIND_MOVE;
      end
      default: begin
        push_data.kind = KIND_NOP;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/tmcw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_queue
// Short queue of decoded commands between front and back end.
// ----------------------------------------------------------------------------
module tmcw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  tmcw_pkg::dcmd_t   push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tmcw_pkg::dcmd_t   pop_data
);
  import tmcw_pkg::*;

  dcmd_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/tmcw_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_exec
// Back end: cursor and attribute state, cell write generation, result register.
// ----------------------------------------------------------------------------
module tmcw_exec (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tmcw_pkg::dcmd_t   pop_data,
  tmcw_res_if.source        res
);
  import tmcw_pkg::*;

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ATTR_W-1:0] attr;
  logic [BASE_W-1:0] row_base;
  logic              res_valid;

  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ATTR_W-1:0] attr_next;
  logic [BASE_W-1:0] row_base_next;
  logic              wr_next;
  logic [ADDR_W-1:0] addr_next;
  logic [DATA_W-1:0] data_next;
  logic              last_row;
  logic [BASE_W-1:0] cell_addr;
  logic              take;

  assign pop_ready = !res_valid || res.ready;
  assign take      = pop_valid && pop_ready;
  assign res.valid = res_valid;
  assign last_row  = (row == ROW_W'(ROWS - 1));
  assign cell_addr = row_base + BASE_W'(col);

  always_comb begin
    row_next      = row;
    col_next      = col;
    attr_next     = attr;
    row_base_next = row_base;
    wr_next       = 1'b0;
    addr_next     = '0;
    data_next     = '0;
    unique case (pop_data.kind)
      KIND_WRITE: begin
        wr_next   = 1'b1;
        addr_next = cell_addr[ADDR_W-1:0];
        data_next = {attr, pop_data.char_code};
        if (col == COL_W'(COLS - 1)) begin
          col_next      = '0;
          row_next      = last_row ? '0 : row + ROW_W'(1);
          row_base_next = last_row ? '0 : row_base + BASE_W'(COLS);
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      KIND_NEWLINE: begin
        col_next      = '0;
        row_next      = last_row ? '0 : row + ROW_W'(1);
        row_base_next = last_row ? '0 : row_base + BASE_W'(COLS);
      end
      KIND_ATTR: begin
        attr_next = (attr & ~pop_data.attr_mask) | (pop_data.attr_val & pop_data.attr_mask);
      end
      KIND_MOVE: begin
        row_next      = pop_data.row;
        col_next      = pop_data.col;
        row_base_next = pop_data.row_base;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      attr      <= ATTR_RESET;
      row_base  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        row      <= row_next;
        col      <= col_next;
        attr     <= attr_next;
        row_base <= row_base_next;
      end
      if (pop_ready) begin
        res_valid <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.write_valid <= wr_next;
      res.write_addr  <= addr_next;
      res.write_data  <= data_next;
      res.cursor_row  <= row_next;
      res.cursor_col  <= col_next;
      res.attribute   <= attr_next;
    end
  end

endmodule
`default_nettype wire

// File: test/text_mode_console_writer_core_test.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_core_test
// Drives directed and random console commands into the writer core with
// random gaps on the command side and random stalls on the result side. A
// cursor and attribute predictor in the bench computes each expected cell
// write and cursor state. Every result transaction is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_test;
  import tmcw_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE_LAST  = 3'd7;
  localparam int              PRINT_LIMIT   = 40;

  typedef struct {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ATTR_W-1:0] attribute;
  } cell_result_t;

  logic clk;
  logic rst;

  tmcw_cmd_if cmd_bus ();
  tmcw_res_if res_bus ();

  text_mode_console_writer_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  cell_result_t      expected_cells[$];
  int                err_count;
  int                res_hold;
  bit                cmd_gaps_on;
  bit                res_gaps_on;
  logic [ROW_W-1:0]  scr_row;
  logic [COL_W-1:0]  scr_col;
  logic [ATTR_W-1:0] scr_attr;

  always #1 clk = ~clk;

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cmd_bus.valid       = 1'b0;
    cmd_bus.op          = '0;
    cmd_bus.char_code   = '0;
    cmd_bus.color_value = '0;
    cmd_bus.goto_row    = '0;
    cmd_bus.goto_col    = '0;
    res_bus.ready       = 1'b0;
    res_hold            = 0;
    err_count           = 0;
    cmd_gaps_on         = 1'b1;
    res_gaps_on         = 1'b1;
    scr_row             = '0;
    scr_col             = '0;
    scr_attr            = ATTR_RESET;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < PRINT_LIMIT) $display("ERROR: %s", msg);
    err_count++;
  endtask

  function automatic logic [ROW_W-1:0] next_row(logic [ROW_W-1:0] r);
    return (int'(r) + 1 >= ROWS) ? '0 : r + 1'b1;
  endfunction

  function automatic cell_result_t predict_cell(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                                logic [ATTR_W-1:0] color,
                                                logic [ROW_W-1:0] trow,
                                                logic [COL_W-1:0] tcol);
    cell_result_t c;
    c.write_valid = 1'b0;
    c.write_addr  = '0;
    c.write_data  = '0;
    case (op)
      OP_PUT_CHAR: begin
        if (ch == NEWLINE_CODE) begin
          scr_col = '0;
          scr_row = next_row(scr_row);
        end else begin
          c.write_valid = 1'b1;
          c.write_addr  = ADDR_W'(int'(scr_row) * COLS + int'(scr_col));
          c.write_data  = {scr_attr, ch};
          if (int'(scr_col) + 1 >= COLS) begin
            scr_col = '0;
            scr_row = next_row(scr_row);
          end else begin
            scr_col = scr_col + 1'b1;
          end
        end
      end
      OP_SET_ATTR: scr_attr = color;
      OP_SET_FG:   scr_attr = {scr_attr[7:4], color[3:0]};
      OP_SET_BG:   scr_attr = {color[3:0], scr_attr[3:0]};
      OP_MOVE: begin
        scr_row = (int'(trow) > ROWS - 1) ? ROW_W'(ROWS - 1) : trow;
        scr_col = (int'(tcol) > COLS - 1) ? COL_W'(COLS - 1) : tcol;
      end
      default: ;
    endcase
    c.cursor_row = scr_row;
    c.cursor_col = scr_col;
    c.attribute  = scr_attr;
    return c;
  endfunction

  task automatic send_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                              logic [ATTR_W-1:0] color, logic [ROW_W-1:0] trow,
                              logic [COL_W-1:0] tcol);
    int gap;
    gap = pick_gap(cmd_gaps_on);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.op          <= op;
    cmd_bus.char_code   <= ch;
    cmd_bus.color_value <= color;
    cmd_bus.goto_row    <= trow;
    cmd_bus.goto_col    <= tcol;
    do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
    expected_cells.push_back(predict_cell(op, ch, color, trow, tcol));
  endtask

  task automatic send_char(logic [CHAR_W-1:0] ch);
    send_command(OP_PUT_CHAR, ch, ATTR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic send_move(logic [ROW_W-1:0] trow, logic [COL_W-1:0] tcol);
    send_command(OP_MOVE, CHAR_W'($urandom), ATTR_W'($urandom), trow, tcol);
  endtask

  task automatic send_color(logic [OP_W-1:0] op, logic [ATTR_W-1:0] color);
    send_command(op, CHAR_W'($urandom), color, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic send_idle_op(logic [OP_W-1:0] op);
    send_command(op, CHAR_W'($urandom), ATTR_W'($urandom), ROW_W'($urandom),
                 COL_W'($urandom));
  endtask

  always @(posedge clk) begin
    if (res_hold != 0) begin
      res_bus.ready <= 1'b0;
      res_hold      <= res_hold - 1;
    end else begin
      res_bus.ready <= 1'b1;
      res_hold      <= pick_gap(res_gaps_on);
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("result transaction with no command pending");
      end else begin
        want = expected_cells.pop_front();
        if (res_bus.write_valid !== want.write_valid)
          report_mismatch($sformatf("write_valid got %0b expected %0b",
                                    res_bus.write_valid, want.write_valid));
        if (res_bus.write_addr !== want.write_addr)
          report_mismatch($sformatf("write_addr got %0d expected %0d",
                                    res_bus.write_addr, want.write_addr));
        if (res_bus.write_data !== want.write_data)
          report_mismatch($sformatf("write_data got %h expected %h",
                                    res_bus.write_data, want.write_data));
        if (res_bus.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                    res_bus.cursor_row, want.cursor_row));
        if (res_bus.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                    res_bus.cursor_col, want.cursor_col));
        if (res_bus.attribute !== want.attribute)
          report_mismatch($sformatf("attribute got %h expected %h",
                                    res_bus.attribute, want.attribute));
      end
    end
  end

  task automatic test_directed();
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(NEWLINE_CODE);
    send_color(OP_SET_ATTR, 8'h00);
    send_char(8'h20);
    send_color(OP_SET_ATTR, 8'hFF);
    send_color(OP_SET_FG, 8'hA5);
    send_color(OP_SET_BG, 8'h5A);
    send_char(8'h7E);
    send_move(5'd0, 7'd0);
    send_move(5'd31, 7'd127);
    send_char(8'h23);
    send_move(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
    send_char(8'h58);
    send_move(ROW_W'(ROWS - 1), 7'd10);
    send_char(NEWLINE_CODE);
    send_move(5'd0, COL_W'(COLS - 1));
    send_char(8'h59);
    send_move(ROW_W'(ROWS), 7'd3);
    send_move(5'd7, COL_W'(COLS));
    send_idle_op(OP_NONE_FIRST);
    send_idle_op(OP_NONE_MID);
    send_idle_op(OP_NONE_LAST);
    send_char(8'h5A);
  endtask

  task automatic test_random_commands(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        cmd_gaps_on = ($urandom_range(0, 3) != 0);
        res_gaps_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 55)      send_char(CHAR_W'($urandom));
      else if (r < 62) send_char(NEWLINE_CODE);
      else if (r < 70) send_color(OP_SET_ATTR, ATTR_W'($urandom));
      else if (r < 76) send_color(OP_SET_FG, ATTR_W'($urandom));
      else if (r < 82) send_color(OP_SET_BG, ATTR_W'($urandom));
      else if (r < 95) send_move(ROW_W'($urandom), COL_W'($urandom));
      else send_idle_op(OP_W'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST)));
    end
  endtask

  task automatic test_text_stream(int bursts);
    int len;
    for (int b = 0; b < bursts; b++) begin
      cmd_gaps_on = b[0];
      res_gaps_on = b[1];
      send_move(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom_range(0, COLS - 1)));
      len = $urandom_range(20, 200);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 3) send_char(NEWLINE_CODE);
        else send_char(CHAR_W'($urandom));
      end
    end
  endtask

  task automatic wait_drain();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_commands(600);
    test_text_stream(4);
    cmd_bus.valid <= 1'b0;
    wait_drain();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
